@@ rtl/sem_pkg.sv @@
// Package with shared constants and types for the Sobel edge magnitude block.
`timescale 1ns / 1ps
package sem_pkg;
  localparam int MaxWidth = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW = $clog2(MaxWidth);
  localparam int DimW = 11;
  localparam int PixW = 24;
  localparam logic [DimW-1:0] WidthReset = 11'd640;
  localparam logic [DimW-1:0] HeightReset = 11'd480;
  localparam logic [2:0] RegFrameWidth = 3'd0;
  localparam logic [2:0] RegFrameHeight = 3'd4;

  typedef logic [PixW-1:0] pix_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] maxv);
    if (v == '0) begin
      return {{(DimW-1){1'b0}}, 1'b1};
    end
    if (v > maxv) begin
      return maxv;
    end
    return v;
  endfunction
endpackage

@@ rtl/sobel_edge_magnitude_rgb.sv @@
// Top level of the streaming 3x3 Sobel edge magnitude block for RGB pixels.
//
// Channel | Direction | Contents
// in_     | slave     | tdata {blue, green, red}, tuser func
// out_    | master    | tdata {edge_blue, edge_green, edge_red}, tuser {frame_end, row_end, last}
// cfg_    | APB       | frame_width at 0x0, frame_height at 0x4
//
// A request passes through the line store read (S_READ) and the window update
// (S_UPD), then yields no result, one, or two at the last column of a row. Each
// result runs through start (S_MAG), the shared square root unit, which handles
// one channel at a time with one root bit per cycle, and hand-off (S_WAIT, S_OUT).
// Reset is synchronous and active low. An output stall holds the block in S_OUT.
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // red, green, blue
  input  logic        in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // edge_red, edge_green, edge_blue
  output logic [2:0]  out_tuser, // last_of_run, row_end, frame_end
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sem_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_UPD  = 6'b000100,
    S_MAG  = 6'b001000,
    S_WAIT = 6'b010000,
    S_OUT  = 6'b100000
  } st_t;

  st_t st_r, st_nxt;
  logic [DimW-1:0] fw_r, fh_r, w_c, h_c;
  logic [DimW-1:0] row_r, r_c, r_r;
  logic [DimW-1:0] col_r, c_c;
  logic [ColW-1:0] c_r;
  pix_t pix_r, top_d, mid_d;
  pix_t win_r [9];
  pix_t mwin [9];
  logic second_r, two_r, fe_r;
  logic cfg_wr, mstart, mdone;
  logic [23:0] mag;
  logic [23:0] odata_r;
  logic [2:0] ouser_r;
  logic ov_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    unique case (cfg_paddr)
      RegFrameWidth: cfg_prdata = {21'd0, fw_r};
      RegFrameHeight: cfg_prdata = {21'd0, fh_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign w_c = clamp_dim(fw_r, DimW'(MaxWidth));
  assign h_c = clamp_dim(fh_r, DimW'(MaxHeight));
  assign c_c = (col_r >= w_c) ? '0 : col_r;
  assign r_c = (row_r > h_c) ? '0 : row_r;
  assign in_tready = (st_r == S_IDLE);

  sem_ram #(.Width(PixW), .Depth(MaxWidth)) u_upper (
    .clk(clk), .we(st_r == S_UPD), .waddr(c_r), .wdata(mid_d),
    .raddr(c_r), .rdata(top_d)
  );
  sem_ram #(.Width(PixW), .Depth(MaxWidth)) u_middle (
    .clk(clk), .we(st_r == S_UPD), .waddr(c_r), .wdata(pix_r),
    .raddr(c_r), .rdata(mid_d)
  );

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mwin[i] = win_r[i];
    end
    if (second_r) begin
      for (int i = 0; i < 6; i++) begin
        mwin[i] = win_r[i+3];
      end
      for (int i = 6; i < 9; i++) begin
        mwin[i] = '0;
      end
    end
  end

  assign mstart = (st_r == S_MAG);
  sem_mag u_mag (
    .clk(clk), .rst_n(rst_n), .start(mstart), .win(mwin), .done(mdone), .mag(mag)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_tvalid) st_nxt = S_READ;
      S_READ: st_nxt = S_UPD;
      S_UPD: begin
        if (r_r != '0 && (c_r != '0 || two_r)) begin
          st_nxt = S_MAG;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_MAG: st_nxt = S_WAIT;
      S_WAIT: if (mdone) st_nxt = S_OUT;
      S_OUT: begin
        if (!ov_r) begin
          st_nxt = (!second_r && two_r && c_r != '0) ? S_MAG : S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      fw_r <= WidthReset;
      fh_r <= HeightReset;
      row_r <= '0;
      col_r <= '0;
      ov_r <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_tready) ov_r <= 1'b0;
      if (cfg_wr && (cfg_paddr == RegFrameWidth || cfg_paddr == RegFrameHeight)) begin
        if (cfg_paddr == RegFrameWidth) fw_r <= cfg_pwdata[DimW-1:0];
        else fh_r <= cfg_pwdata[DimW-1:0];
        row_r <= '0;
        col_r <= '0;
        for (int i = 0; i < 9; i++) win_r[i] <= '0;
      end
      if (st_r == S_IDLE && in_tvalid) begin
        c_r <= ColW'(c_c);
        r_r <= r_c;
        pix_r <= (r_c < h_c && !in_tuser) ? in_tdata : '0;
        two_r <= (c_c == w_c - 11'd1);
        fe_r <= (r_c == h_c);
        second_r <= 1'b0;
        if (c_c + 11'd1 >= w_c) begin
          col_r <= '0;
          row_r <= (r_c + 11'd1 > h_c) ? '0 : r_c + 11'd1;
        end else begin
          col_r <= c_c + 11'd1;
        end
      end
      if (st_r == S_UPD) begin
        for (int i = 0; i < 6; i++) win_r[i] <= (c_r == '0) ? '0 : win_r[i+3];
        win_r[6] <= (r_r >= 11'd2) ? top_d : '0;
        win_r[7] <= (r_r != '0) ? mid_d : '0;
        win_r[8] <= pix_r;
        if (c_r == '0) second_r <= 1'b1;
      end
      if (st_r == S_WAIT && mdone) begin
        odata_r <= mag;
        ouser_r <= {second_r && fe_r, second_r, second_r || !two_r};
        ov_r <= 1'b1;
      end
      if (st_r == S_OUT && !ov_r) second_r <= 1'b1;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = odata_r;
  assign out_tuser = ouser_r;
endmodule

@@ rtl/sem_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module sem_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/sem_mag.sv @@
// Gradient magnitude unit: Sobel sums, squares and an iterative square root.
`timescale 1ns / 1ps
module sem_mag (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sem_pkg::pix_t       win [9],
  output logic                done,
  output logic [23:0]         mag
);
  import sem_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQ   = 4'b0010,
    S_ROOT = 4'b0100,
    S_DONE = 4'b1000
  } st_t;

  st_t st_r, st_nxt;
  logic [1:0] ch_r, ch_nxt;
  logic [3:0] step_r, step_nxt;
  logic [20:0] s_r, s_nxt, rem_r, rem_nxt, q_r, q_nxt;
  logic [21:0] bit_r, bit_nxt;
  logic [23:0] mag_r, mag_nxt;
  logic signed [10:0] p [9];
  logic signed [10:0] gx_c, gy_c;
  logic [21:0] gx_sq, gy_sq;
  logic [21:0] trial;
  logic [7:0] cap;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = {3'b000, win[i][8*ch_r +: 8]};
    end
    gx_c = (p[6] - p[0]) + ((p[7] - p[1]) <<< 1) + (p[8] - p[2]);
    gy_c = (p[2] - p[0]) + ((p[5] - p[3]) <<< 1) + (p[8] - p[6]);
    gx_sq = {{11{gx_c[10]}}, gx_c} * {{11{gx_c[10]}}, gx_c};
    gy_sq = {{11{gy_c[10]}}, gy_c} * {{11{gy_c[10]}}, gy_c};
  end

  assign trial = {1'b0, q_r} + bit_r;

  always_comb begin
    st_nxt = st_r;
    ch_nxt = ch_r;
    step_nxt = step_r;
    s_nxt = s_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    bit_nxt = bit_r;
    mag_nxt = mag_r;
    cap = 8'd0;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          ch_nxt = 2'd0;
          st_nxt = S_SQ;
        end
      end
      S_SQ: begin
        s_nxt = gx_sq[20:0] + gy_sq[20:0];
        rem_nxt = gx_sq[20:0] + gy_sq[20:0];
        q_nxt = '0;
        bit_nxt = 22'h100000;
        step_nxt = '0;
        st_nxt = S_ROOT;
      end
      S_ROOT: begin
        if ({1'b0, rem_r} >= trial) begin
          rem_nxt = 21'({1'b0, rem_r} - trial);
          q_nxt = 21'((q_r >> 1) + bit_r[20:0]);
        end else begin
          q_nxt = q_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd10) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if ({1'b0, s_r} > ({1'b0, q_r} * {1'b0, q_r} + {1'b0, q_r})) begin
          cap = (q_r >= 21'd255) ? 8'd255 : 8'(q_r + 21'd1);
        end else begin
          cap = (q_r > 21'd255) ? 8'd255 : q_r[7:0];
        end
        mag_nxt[8*ch_r +: 8] = cap;
        if (ch_r == 2'd2) begin
          st_nxt = S_IDLE;
        end else begin
          ch_nxt = ch_r + 2'd1;
          st_nxt = S_SQ;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    ch_r <= ch_nxt;
    step_r <= step_nxt;
    s_r <= s_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    bit_r <= bit_nxt;
    mag_r <= mag_nxt;
  end

  assign done = (st_r == S_DONE) && (ch_r == 2'd2);
  assign mag = mag_nxt;
endmodule

@@ rtl/sem_checker.sv @@
// Port-level checker for the Sobel edge magnitude block, with its bind.
`timescale 1ns / 1ps
module sem_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        cfg_pready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");
  a_fe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1] && out_tuser[0])
    else $error("frame end without row end");
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .cfg_pready(cfg_pready)
);
